[rtl/core/ght_pkg.sv]
// ght_pkg: status and command codes, controller/datapath interface structs
// and the group priority encoder for the generational handle table
// no dependencies
`timescale 1ns / 1ps

package ght_pkg;

  // command codes
  localparam logic [1:0] CMD_CREATE  = 2'd0;
  localparam logic [1:0] CMD_REMOVE  = 2'd1;
  localparam logic [1:0] CMD_TOUCH   = 2'd2;
  localparam logic [1:0] CMD_RESOLVE = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_INVALID       = 3'd1;
  localparam logic [2:0] ST_UNSUPPORTED   = 3'd2;
  localparam logic [2:0] ST_FULL          = 3'd3;
  localparam logic [2:0] ST_GEN_EXHAUSTED = 3'd4;
  localparam logic [2:0] ST_COLLISION_BAD = 3'd5;
  localparam logic [2:0] ST_REV_EXHAUSTED = 3'd6;
  localparam logic [2:0] ST_STALE         = 3'd7;

  localparam logic [7:0] GEN_MAX = 8'hff;

  // slots examined per scan cycle
  localparam int GRP_BITS = 16;
  localparam int GRP_POS_W = 4;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture the input transaction
    logic check;  // early request checks, clear scan pointer
    logic scan;   // examine one group of slots
    logic read;   // read the generation memory
    logic exec;   // apply the command and settle the status
    logic emit;   // load the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic early_done;  // request settled without a slot lookup
    logic is_create;
    logic scan_hit;
    logic scan_last;
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    logic                 hit;
    logic [GRP_POS_W-1:0] pos;
  } prio_t;

  // lowest clear bit of a group
  function automatic prio_t prio_free(input logic [GRP_BITS-1:0] bits);
    prio_t r;
    r.hit = 1'b0;
    r.pos = '0;
    for (int i = GRP_BITS - 1; i >= 0; i--) begin
      if (!bits[i]) begin
        r.hit = 1'b1;
        r.pos = GRP_POS_W'(i);
      end
    end
    return r;
  endfunction

endpackage

[rtl/core/ght_ctrl.sv]
// ght_ctrl: sequencing state machine of the generational handle table
// depends on ght_pkg
`timescale 1ns / 1ps

module ght_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ght_pkg::dp_stat_t  stat_i,
  output ght_pkg::ctrl_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EXEC  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        if (stat_i.early_done) begin
          state_d = S_DONE;
        end else if (stat_i.is_create) begin
          state_d = S_SCAN;
        end else begin
          state_d = S_READ;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_hit) begin
          state_d = S_READ;
        end else if (stat_i.scan_last) begin
          state_d = S_DONE;
        end
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/core/ght_datapath.sv]
// ght_datapath: slot occupancy, generation memory, counters and result register
// depends on ght_pkg
`timescale 1ns / 1ps

module ght_datapath #(
  parameter int SLOT_COUNT = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ght_pkg::ctrl_cmd_t cmd_i,
  output ght_pkg::dp_stat_t  stat_o,
  input  logic [1:0]         command_i,
  input  logic signed [31:0] handle_i,
  input  logic signed [15:0] model_id_i,
  input  logic [4:0]         name_length_i,
  input  logic               position_finite_i,
  input  logic               below_ground_i,
  input  logic               no_offset_i,
  input  logic               collision_base_ok_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [23:0]        handle_out_o,
  output logic [6:0]         live_count_o,
  output logic [63:0]        revision_o
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int NGRP  = (SLOT_COUNT + ght_pkg::GRP_BITS - 1) / ght_pkg::GRP_BITS;
  localparam int GRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int SIDX_W = GRP_W + ght_pkg::GRP_POS_W;

  // captured transaction
  logic [1:0]  cmd_q;
  logic        h_neg_q;
  logic [7:0]  h_gen_q;
  logic [15:0] h_idx_q;
  logic        req_bad_q, below_q, coll_bad_q;

  // table state
  logic [SLOT_COUNT-1:0] used_q;
  logic [SLOT_COUNT-1:0] gen_vld_q;
  logic [7:0]            gen_mem [SLOT_COUNT];
  logic [CNT_W-1:0]      cnt_q;
  logic [63:0]           rev_q;

  // per-item working registers
  logic [GRP_W-1:0] grp_q;
  logic [IDX_W-1:0] slot_q;
  logic [7:0]       rd_gen_q;
  logic             rd_vld_q;
  logic [2:0]       res_status_q;
  logic [23:0]      res_handle_q;

  // output register
  logic        out_valid_q;
  logic [2:0]  out_status_q;
  logic [23:0] out_handle_q;
  logic [6:0]  out_live_q;
  logic [63:0] out_rev_q;

  logic                         is_create, oor, early_done;
  logic [2:0]                   early_status;
  logic [NGRP*ght_pkg::GRP_BITS-1:0] used_pad;
  ght_pkg::prio_t               prio;
  logic [SIDX_W-1:0]            scan_idx;
  logic                         scan_last;
  logic [IDX_W-1:0]             rd_addr;
  logic [7:0]                   gen_cur, gen_next;
  logic                         bump, commit_create, gen_match;
  logic                         commit_remove, commit_touch;
  logic [CNT_W+6:0]             cnt_ext;

  assign is_create = (cmd_q == ght_pkg::CMD_CREATE);
  assign oor       = ({1'b0, h_idx_q} >= 17'(SLOT_COUNT));

  always_comb begin
    early_done   = 1'b0;
    early_status = ght_pkg::ST_OK;
    if (is_create) begin
      if (req_bad_q) begin
        early_done   = 1'b1;
        early_status = ght_pkg::ST_INVALID;
      end else if (below_q) begin
        early_done   = 1'b1;
        early_status = ght_pkg::ST_UNSUPPORTED;
      end
    end else if (h_neg_q && cmd_q == ght_pkg::CMD_REMOVE) begin
      early_done   = 1'b1;
      early_status = ght_pkg::ST_INVALID;
    end else if (h_neg_q || oor || !used_q[h_idx_q[IDX_W-1:0]]) begin
      early_done   = 1'b1;
      early_status = ght_pkg::ST_STALE;
    end
  end

  // padding slots count as used so the scan never lands on them
  always_comb begin
    used_pad                 = '1;
    used_pad[SLOT_COUNT-1:0] = used_q;
  end

  assign prio      = ght_pkg::prio_free(used_pad[grp_q*ght_pkg::GRP_BITS +: ght_pkg::GRP_BITS]);
  assign scan_idx  = {grp_q, prio.pos};
  assign scan_last = (grp_q == GRP_W'(NGRP - 1));
  assign rd_addr   = is_create ? slot_q : h_idx_q[IDX_W-1:0];

  assign gen_cur       = rd_vld_q ? rd_gen_q : 8'd0;
  assign gen_next      = gen_cur + 8'd1;
  assign bump          = cmd_i.exec && is_create && (gen_cur != ght_pkg::GEN_MAX);
  assign commit_create = bump && !coll_bad_q && !(&rev_q);
  assign gen_match     = (gen_cur == h_gen_q);
  assign commit_remove = cmd_i.exec && gen_match && (cmd_q == ght_pkg::CMD_REMOVE);
  assign commit_touch  = cmd_i.exec && gen_match && (cmd_q == ght_pkg::CMD_TOUCH);

  assign stat_o.early_done = early_done;
  assign stat_o.is_create  = is_create;
  assign stat_o.scan_hit   = prio.hit;
  assign stat_o.scan_last  = scan_last;
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

  // generation memory
  always_ff @(posedge clk_i) begin
    if (bump) begin
      gen_mem[slot_q] <= gen_next;
    end
    if (cmd_i.read) begin
      rd_gen_q <= gen_mem[rd_addr];
    end
  end

  // captured fields and per-item registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q      <= command_i;
      h_neg_q    <= handle_i[31];
      h_gen_q    <= handle_i[23:16];
      h_idx_q    <= handle_i[15:0];
      req_bad_q  <= !position_finite_i || model_id_i[15] || (name_length_i == 5'd0);
      below_q    <= below_ground_i;
      coll_bad_q <= !no_offset_i && !collision_base_ok_i;
    end
    if (cmd_i.check) begin
      grp_q        <= '0;
      res_status_q <= early_status;
      res_handle_q <= '0;
    end
    if (cmd_i.scan) begin
      if (prio.hit) begin
        slot_q <= scan_idx[IDX_W-1:0];
      end else if (scan_last) begin
        res_status_q <= ght_pkg::ST_FULL;
      end else begin
        grp_q <= grp_q + GRP_W'(1);
      end
    end
    if (cmd_i.read) begin
      rd_vld_q <= gen_vld_q[rd_addr];
    end
    if (cmd_i.exec) begin
      if (is_create) begin
        if (gen_cur == ght_pkg::GEN_MAX) begin
          res_status_q <= ght_pkg::ST_GEN_EXHAUSTED;
        end else if (coll_bad_q) begin
          res_status_q <= ght_pkg::ST_COLLISION_BAD;
        end else if (&rev_q) begin
          res_status_q <= ght_pkg::ST_REV_EXHAUSTED;
        end else begin
          res_status_q <= ght_pkg::ST_OK;
          res_handle_q <= {gen_next, 16'(slot_q)};
        end
      end else begin
        res_status_q <= gen_match ? ght_pkg::ST_OK : ght_pkg::ST_STALE;
      end
    end
  end

  // table state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      gen_vld_q <= '0;
      cnt_q     <= '0;
      rev_q     <= '0;
    end else begin
      if (bump) begin
        gen_vld_q[slot_q] <= 1'b1;
      end
      if (commit_create) begin
        used_q[slot_q] <= 1'b1;
        cnt_q          <= cnt_q + CNT_W'(1);
        rev_q          <= rev_q + 64'd1;
      end
      if (commit_remove) begin
        used_q[h_idx_q[IDX_W-1:0]] <= 1'b0;
        cnt_q                      <= cnt_q - CNT_W'(1);
        rev_q                      <= rev_q + 64'd1;
      end
      if (commit_touch) begin
        rev_q <= rev_q + 64'd1;
      end
    end
  end

  assign cnt_ext = {7'd0, cnt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q <= res_status_q;
      out_handle_q <= res_handle_q;
      out_live_q   <= cnt_ext[6:0];
      out_rev_q    <= rev_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign handle_out_o = out_handle_q;
  assign live_count_o = out_live_q;
  assign revision_o   = out_rev_q;

endmodule

[rtl/core/generational_handle_table.sv]
// generational_handle_table: top level, controller plus datapath
// depends on ght_pkg, ght_ctrl, ght_datapath
`timescale 1ns / 1ps

// channel   direction  handshake               payload
// in        input      in_valid_i / in_stall_o  command, handle, model_id, flags
// out       output     out_valid_o / out_stall_i status, handle_out, live_count, revision
//
// one transaction at a time; steps from acceptance to the output register:
//   rejected (bad fields, negative or out-of-range handle, free slot): load, check, emit
//   remove, touch, resolve of an occupied slot: load, check, read, execute, emit
//   create: load, check, scan of g groups of 16 slots up to the first free one,
//   at most ceil(SLOT_COUNT/16), then read, execute, emit; a full pool emits after the last group;
//   the generation memory read is registered
// reset clears occupancy and generation-valid flip-flops at once, no clearing pass
// a stalled result holds in the output register; the next transaction is taken
// meanwhile and waits in its final state until the register frees up

module generational_handle_table #(
  parameter int SLOT_COUNT = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         command_i,
  input  logic signed [31:0] handle_i,
  input  logic signed [15:0] model_id_i,
  input  logic [4:0]         name_length_i,
  input  logic               position_finite_i,
  input  logic               below_ground_i,
  input  logic               no_offset_i,
  input  logic               collision_base_ok_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [23:0]        handle_out_o,
  output logic [6:0]         live_count_o,
  output logic [63:0]        revision_o
);

  // command and status between the sequencer and the datapath
  ght_pkg::ctrl_cmd_t cmd;
  ght_pkg::dp_stat_t  stat;

  // sequencer: accept, check, scan, read, execute, emit
  ght_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // slot table, generation memory, counters and output register
  ght_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .command_i           (command_i),
    .handle_i            (handle_i),
    .model_id_i          (model_id_i),
    .name_length_i       (name_length_i),
    .position_finite_i   (position_finite_i),
    .below_ground_i      (below_ground_i),
    .no_offset_i         (no_offset_i),
    .collision_base_ok_i (collision_base_ok_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_o            (status_o),
    .handle_out_o        (handle_out_o),
    .live_count_o        (live_count_o),
    .revision_o          (revision_o)
  );

`ifndef SYNTH
  // the sequencer issues at most one step per cycle
  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.check, cmd.scan, cmd.read, cmd.exec, cmd.emit}))
    else $error("more than one datapath step in a cycle");

  // an accepted transaction is checked in the next cycle
  a_check_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> cmd.check)
    else $error("accepted transaction not checked");

  // a result is only loaded when the output register can take it
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> stat.out_free)
    else $error("result loaded over a pending result");

  // only a successful create carries a handle
  a_handle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ght_pkg::ST_OK) |-> (handle_out_o == 24'd0))
    else $error("handle reported on a failed transaction");
`endif

endmodule
